// ===== rtl/tvpd_pkg.sv =====
`default_nettype none
package tvpd_pkg;

  // Field widths
  localparam int COORD_BITS  = 12;
  localparam int CFG_COORD_W = 12;
  localparam int DZ_W        = 25;
  localparam int DELTA_W     = COORD_BITS + 1;
  localparam int SQ_W        = 2 * COORD_BITS;
  localparam int DIST_W      = SQ_W + 1;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  // Pad modes; code three is unreachable and treated as idle
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STICK  = 2'd1,
    MODE_BUTTON = 2'd2
  } pad_mode_t;

  // Direction codes
  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_t;

  // Register indexes (word address bits)
  typedef enum logic [2:0] {
    REG_BUTTON_X_MIN = 3'd0,
    REG_BUTTON_X_MAX = 3'd1,
    REG_BUTTON_Y_MIN = 3'd2,
    REG_BUTTON_Y_MAX = 3'd3,
    REG_STICK_X_MAX  = 3'd4,
    REG_STICK_Y_MAX  = 3'd5,
    REG_DEAD_ZONE    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_COORD_W-1:0] button_x_min;
    logic [CFG_COORD_W-1:0] button_x_max;
    logic [CFG_COORD_W-1:0] button_y_min;
    logic [CFG_COORD_W-1:0] button_y_max;
    logic [CFG_COORD_W-1:0] stick_x_max;
    logic [CFG_COORD_W-1:0] stick_y_max;
    logic [DZ_W-1:0]        dead_zone_squared;
  } cfg_t;

  typedef struct packed {
    pad_mode_t             mode;
    logic [COORD_BITS-1:0] ref_x;
    logic [COORD_BITS-1:0] ref_y;
  } pad_state_t;

  typedef struct packed {
    logic handled;
    logic direction_written;
    dir_t direction;
    logic shift_written;
    logic shift;
  } result_t;

  // Reset values of the registers
  localparam logic [CFG_COORD_W-1:0] RST_BUTTON_X_MIN = CFG_COORD_W'(256);
  localparam logic [CFG_COORD_W-1:0] RST_BUTTON_X_MAX = CFG_COORD_W'(512);
  localparam logic [CFG_COORD_W-1:0] RST_BUTTON_Y_MIN = CFG_COORD_W'(96);
  localparam logic [CFG_COORD_W-1:0] RST_BUTTON_Y_MAX = CFG_COORD_W'(448);
  localparam logic [CFG_COORD_W-1:0] RST_STICK_X_MAX  = CFG_COORD_W'(256);
  localparam logic [CFG_COORD_W-1:0] RST_STICK_Y_MAX  = CFG_COORD_W'(448);
  localparam logic [DZ_W-1:0]        RST_DEAD_ZONE    = DZ_W'(1024);

endpackage
`default_nettype wire

// ===== rtl/tvpd_cfg.sv =====
`default_nettype none
module tvpd_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tvpd_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [tvpd_pkg::DATA_W-1:0]   pwdata,
  output logic      [tvpd_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output tvpd_pkg::cfg_t                     cfg
);

  tvpd_pkg::cfg_t     cfg_r;
  tvpd_pkg::reg_idx_t reg_idx;
  logic               wr_en;

  assign reg_idx = tvpd_pkg::reg_idx_t'(paddr[tvpd_pkg::ADDR_W-1:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // Write the addressed register; drop writes past the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.button_x_min      <= tvpd_pkg::RST_BUTTON_X_MIN;
      cfg_r.button_x_max      <= tvpd_pkg::RST_BUTTON_X_MAX;
      cfg_r.button_y_min      <= tvpd_pkg::RST_BUTTON_Y_MIN;
      cfg_r.button_y_max      <= tvpd_pkg::RST_BUTTON_Y_MAX;
      cfg_r.stick_x_max       <= tvpd_pkg::RST_STICK_X_MAX;
      cfg_r.stick_y_max       <= tvpd_pkg::RST_STICK_Y_MAX;
      cfg_r.dead_zone_squared <= tvpd_pkg::RST_DEAD_ZONE;
    end else if (wr_en) begin
      unique case (reg_idx)
        tvpd_pkg::REG_BUTTON_X_MIN:
          cfg_r.button_x_min <= pwdata[tvpd_pkg::CFG_COORD_W-1:0];
        tvpd_pkg::REG_BUTTON_X_MAX:
          cfg_r.button_x_max <= pwdata[tvpd_pkg::CFG_COORD_W-1:0];
        tvpd_pkg::REG_BUTTON_Y_MIN:
          cfg_r.button_y_min <= pwdata[tvpd_pkg::CFG_COORD_W-1:0];
        tvpd_pkg::REG_BUTTON_Y_MAX:
          cfg_r.button_y_max <= pwdata[tvpd_pkg::CFG_COORD_W-1:0];
        tvpd_pkg::REG_STICK_X_MAX:
          cfg_r.stick_x_max <= pwdata[tvpd_pkg::CFG_COORD_W-1:0];
        tvpd_pkg::REG_STICK_Y_MAX:
          cfg_r.stick_y_max <= pwdata[tvpd_pkg::CFG_COORD_W-1:0];
        tvpd_pkg::REG_DEAD_ZONE:
          cfg_r.dead_zone_squared <= pwdata[tvpd_pkg::DZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      tvpd_pkg::REG_BUTTON_X_MIN: prdata = tvpd_pkg::DATA_W'(cfg_r.button_x_min);
      tvpd_pkg::REG_BUTTON_X_MAX: prdata = tvpd_pkg::DATA_W'(cfg_r.button_x_max);
      tvpd_pkg::REG_BUTTON_Y_MIN: prdata = tvpd_pkg::DATA_W'(cfg_r.button_y_min);
      tvpd_pkg::REG_BUTTON_Y_MAX: prdata = tvpd_pkg::DATA_W'(cfg_r.button_y_max);
      tvpd_pkg::REG_STICK_X_MAX:  prdata = tvpd_pkg::DATA_W'(cfg_r.stick_x_max);
      tvpd_pkg::REG_STICK_Y_MAX:  prdata = tvpd_pkg::DATA_W'(cfg_r.stick_y_max);
      tvpd_pkg::REG_DEAD_ZONE:    prdata = tvpd_pkg::DATA_W'(cfg_r.dead_zone_squared);
      default:                    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/tvpd_decode.sv =====
`default_nettype none
module tvpd_decode (
  input  wire logic [tvpd_pkg::COORD_BITS-1:0] touch_x,
  input  wire logic [tvpd_pkg::COORD_BITS-1:0] touch_y,
  input  wire logic                            pressed,
  input  wire tvpd_pkg::cfg_t                  cfg,
  input  wire tvpd_pkg::pad_state_t            cur,
  output tvpd_pkg::pad_state_t                 nxt,
  output tvpd_pkg::result_t                    res
);

  localparam int SEC_W = tvpd_pkg::DELTA_W + 1;
  localparam int CMP_W = (tvpd_pkg::DIST_W > tvpd_pkg::DZ_W) ?
                         tvpd_pkg::DIST_W : tvpd_pkg::DZ_W;
  localparam int CRD_W = (tvpd_pkg::COORD_BITS > tvpd_pkg::CFG_COORD_W) ?
                         tvpd_pkg::COORD_BITS : tvpd_pkg::CFG_COORD_W;

  logic signed [tvpd_pkg::DELTA_W-1:0]   dx;
  logic signed [tvpd_pkg::DELTA_W-1:0]   dy;
  logic signed [2*tvpd_pkg::DELTA_W-1:0] sq_x;
  logic signed [2*tvpd_pkg::DELTA_W-1:0] sq_y;
  logic        [tvpd_pkg::DIST_W-1:0]    sum_sq;
  logic                                  outside_dz;
  logic signed [SEC_W-1:0]               sdx;
  logic signed [SEC_W-1:0]               sdy;
  logic signed [SEC_W-1:0]               ndx;
  logic signed [SEC_W-1:0]               ndy;
  tvpd_pkg::dir_t                        sector;
  logic [CRD_W-1:0]                      cx;
  logic [CRD_W-1:0]                      cy;
  logic                                  in_button;
  logic                                  in_stick;

  // Offset to the reference point and its squared length
  assign dx   = $signed({1'b0, touch_x}) - $signed({1'b0, cur.ref_x});
  assign dy   = $signed({1'b0, touch_y}) - $signed({1'b0, cur.ref_y});
  assign sq_x = dx * dx;
  assign sq_y = dy * dy;
  assign sum_sq = {1'b0, sq_x[tvpd_pkg::SQ_W-1:0]} + {1'b0, sq_y[tvpd_pkg::SQ_W-1:0]};
  assign outside_dz = CMP_W'(sum_sq) >= CMP_W'(cfg.dead_zone_squared);

  // Sector by sign and magnitude compares; half-open on the clockwise side
  assign sdx = SEC_W'(dx);
  assign sdy = SEC_W'(dy);
  assign ndx = -sdx;
  assign ndy = -sdy;

  always_comb begin
    priority if ((sdx == '0) && (sdy == '0)) begin
      sector = tvpd_pkg::DIR_RIGHT;
    end else if ((sdx >= sdy) && (sdx > ndy)) begin
      sector = tvpd_pkg::DIR_RIGHT;
    end else if ((sdy > sdx) && (sdy >= ndx)) begin
      sector = tvpd_pkg::DIR_DOWN;
    end else if ((ndx > sdy) && (sdx <= sdy)) begin
      sector = tvpd_pkg::DIR_LEFT;
    end else begin
      sector = tvpd_pkg::DIR_UP;
    end
  end

  // Region hits, strict bounds on every side
  assign cx = CRD_W'(touch_x);
  assign cy = CRD_W'(touch_y);
  assign in_button = (cx > CRD_W'(cfg.button_x_min)) && (cx < CRD_W'(cfg.button_x_max)) &&
                     (cy > CRD_W'(cfg.button_y_min)) && (cy < CRD_W'(cfg.button_y_max));
  assign in_stick  = (cx != '0) && (cx < CRD_W'(cfg.stick_x_max)) &&
                     (cy != '0) && (cy < CRD_W'(cfg.stick_y_max));

  // Mode step and result fields
  always_comb begin
    nxt = cur;
    res = '0;
    unique case (cur.mode)
      tvpd_pkg::MODE_STICK: begin
        res.handled           = 1'b1;
        res.direction_written = 1'b1;
        if (!pressed) begin
          nxt.mode = tvpd_pkg::MODE_IDLE;
        end else if (outside_dz) begin
          res.direction = sector;
        end
      end
      tvpd_pkg::MODE_BUTTON: begin
        res.handled       = 1'b1;
        res.shift_written = 1'b1;
        res.shift         = pressed;
        if (!pressed) begin
          nxt.mode = tvpd_pkg::MODE_IDLE;
        end else begin
          nxt.ref_x = touch_x;
          nxt.ref_y = touch_y;
        end
      end
      default: begin
        nxt.mode = tvpd_pkg::MODE_IDLE;
        if (pressed && in_button) begin
          nxt.mode          = tvpd_pkg::MODE_BUTTON;
          nxt.ref_x         = touch_x;
          nxt.ref_y         = touch_y;
          res.handled       = 1'b1;
          res.shift_written = 1'b1;
          res.shift         = 1'b1;
        end else if (pressed && in_stick) begin
          nxt.mode    = tvpd_pkg::MODE_STICK;
          nxt.ref_x   = touch_x;
          nxt.ref_y   = touch_y;
          res.handled = 1'b1;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/touch_virtual_pad_decoder.sv =====
`default_nettype none
// Touch virtual pad decoder.
// Input channel (in_valid/in_ready) takes one touch word per cycle while in_ready is high: x, y and
// the pressed flag. Result channel (out_valid/out_ready) returns exactly one
// word per touch word: handled, direction with its write flag, shift with its
// write flag.
// A word accepted moves through two register stages, the input register and
// then the result register, before it is shown on the result port.
// Throughput: one word per cycle while out_ready stays high; the mode and
// reference point update in the same cycle the word moves into the result
// register, so the next word sees them at once. When the receiver stalls,
// the result register holds its word and the input register holds one more;
// in_ready drops only when both are full. Reset (rst_n low, synchronous)
// empties both stages, returns the pad to idle with a zero reference point
// and loads the default region and dead-zone registers. The user must write
// registers over the APB port only while the pad is idle; it is not enforced.
module touch_virtual_pad_decoder (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tvpd_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [tvpd_pkg::DATA_W-1:0]     pwdata,
  output logic      [tvpd_pkg::DATA_W-1:0]     prdata,
  output logic                                 pready,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [tvpd_pkg::COORD_BITS-1:0] in_touch_x,
  input  wire logic [tvpd_pkg::COORD_BITS-1:0] in_touch_y,
  input  wire logic                            in_pressed,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_handled,
  output logic                                 out_direction_written,
  output logic      [2:0]                      out_direction,
  output logic                                 out_shift_written,
  output logic                                 out_shift
);

  tvpd_pkg::cfg_t              cfg;
  tvpd_pkg::pad_state_t        state_r;
  tvpd_pkg::pad_state_t        state_nxt;
  tvpd_pkg::result_t           res_nxt;
  tvpd_pkg::result_t           res_r;
  logic                        s1_valid_r;
  logic                        out_valid_r;
  logic [tvpd_pkg::COORD_BITS-1:0] x_r;
  logic [tvpd_pkg::COORD_BITS-1:0] y_r;
  logic                        pressed_r;
  logic                        advance;
  logic                        in_fire;

  tvpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tvpd_decode u_decode (
    .touch_x (x_r),
    .touch_y (y_r),
    .pressed (pressed_r),
    .cfg     (cfg),
    .cur     (state_r),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  // Handshake: move the held word on when the result register frees up
  assign advance  = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~s1_valid_r | advance;
  assign in_fire  = in_valid & in_ready;

  // Input and result stage valids and pad state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      state_r.mode  <= tvpd_pkg::MODE_IDLE;
      state_r.ref_x <= '0;
      state_r.ref_y <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r       <= in_touch_x;
      y_r       <= in_touch_y;
      pressed_r <= in_pressed;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_handled           = res_r.handled;
  assign out_direction_written = res_r.direction_written;
  assign out_direction         = res_r.direction;
  assign out_shift_written     = res_r.shift_written;
  assign out_shift             = res_r.shift;

endmodule
`default_nettype wire
